>>> rtl/akf_pkg.sv
// Shared types, codes and saturation helpers for the angle and bias Kalman filter.
`default_nettype none

package akf_pkg;

    // Configuration register indexes.
    localparam int          CFG_IDX_W  = 2;
    localparam logic [1:0]  CFG_IDX_QA = 2'd0;
    localparam logic [1:0]  CFG_IDX_QB = 2'd1;
    localparam logic [1:0]  CFG_IDX_R  = 2'd2;

    localparam logic signed [31:0] SAT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;

    typedef enum logic [4:0] {
        ST_IDLE, ST_RATE, ST_M1, ST_M2, ST_A1, ST_A2, ST_T1, ST_T2, ST_T3,
        ST_M3, ST_W3, ST_A3, ST_A4, ST_A5, ST_S, ST_DIV0, ST_DIV0W, ST_DIV1,
        ST_DIV1W, ST_M4, ST_M5, ST_M6, ST_M7, ST_M8, ST_M9, ST_A10, ST_A11,
        ST_DONE
    } t_state;

    // Operand sources for the shared multiplier, adder and divider.
    typedef enum logic [4:0] {
        SRC_ZERO, SRC_ANGLE, SRC_BIAS, SRC_P00, SRC_P01, SRC_P10, SRC_P11,
        SRC_T, SRC_D, SRC_S, SRC_K0, SRC_K1, SRC_Y, SRC_P00T, SRC_P01T,
        SRC_MRES, SRC_DT, SRC_QA, SRC_QB, SRC_R, SRC_MA, SRC_MR
    } t_src;

    // Destinations of the saturating adder.
    typedef enum logic [3:0] {
        DST_NONE, DST_ANGLE, DST_BIAS, DST_P00, DST_P01, DST_P10, DST_P11,
        DST_T, DST_D, DST_S, DST_Y, DST_P00T, DST_P01T
    } t_dst;

    typedef struct packed {
        logic mul_en;
        t_src mul_a;
        t_src mul_b;
        t_src add_a;
        t_src add_b;
        logic add_sub;
        t_dst add_dst;
        logic div_start;
        t_src div_num;
    } t_ctrl;

    // Clamp a 34-bit signed sum to the signed 32-bit range.
    function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
        logic signed [31:0] r;
        if (v[33:31] == 3'b000 || v[33:31] == 3'b111) begin
            r = v[31:0];
        end else if (v[33]) begin
            r = SAT_MIN;
        end else begin
            r = SAT_MAX;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> rtl/angle_bias_kalman_filter.sv
// Top level of the two-state angle and rate bias Kalman filter.
`default_nettype none

// Two-state Kalman filter tracking an angle and a rate bias in signed fixed point
// with FRAC_BITS fraction bits. Each input beat carries a measured angle, a measured
// rate and a time step; each yields one output beat with the filtered angle. All
// arithmetic runs through one shared 32x32 multiplier with a rounding stage, one
// saturating adder and a bit-serial divider under a small sequencer, so the block
// takes one beat at a time. The two gain divisions, one quotient bit per cycle, make up
// most of the work. A finished result sits in an output register, so the next beat is
// taken while it waits. Configuration writes go through a plain write port; the user
// must write only while idle, which the block itself does not enforce.
module angle_bias_kalman_filter
    import akf_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic signed [31:0]   i_measured_angle,
    input  logic signed [31:0]   i_measured_rate,
    input  logic        [23:0]   i_time_step,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic signed [31:0]   o_filtered_angle,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic        [30:0]   i_cfg_data
);

    localparam logic [30:0] RST_QA = 31'(((1 << FRAC_BITS) + 5) / 10);
    localparam logic [30:0] RST_QB = 31'((3 * (1 << FRAC_BITS) + 5) / 10);
    localparam logic [30:0] RST_R  = 31'((15 * (1 << FRAC_BITS) + 50) / 100);
    localparam logic signed [63:0] HALF = 64'sd1 <<< (FRAC_BITS - 1);

    t_state r_state, n_state;
    t_ctrl  w_ctrl;

    logic [30:0] r_qa, r_qb, r_r;
    logic signed [31:0] r_ma, r_mr;
    logic [23:0] r_dt;

    logic signed [31:0] r_angle, r_bias, r_p00, r_p01, r_p10, r_p11;
    logic signed [31:0] r_t, r_d, r_s, r_k0, r_k1, r_y, r_p00t, r_p01t;
    logic signed [63:0] r_prod;
    logic signed [31:0] r_mres;
    logic               r_ov;
    logic signed [31:0] r_out;

    logic signed [31:0] w_mul_a, w_mul_b, w_add_a, w_add_b, w_div_num;
    logic signed [63:0] w_rnd, w_shift;
    logic signed [31:0] w_mres;
    logic signed [33:0] w_sum;
    logic signed [31:0] w_add;
    logic               w_div_done;
    logic signed [31:0] w_div_q;
    logic               w_in_acc;
    logic               w_out_free;

    function automatic logic signed [31:0] sel_val(input t_src sel);
        logic signed [31:0] v;
        unique case (sel)
            SRC_ZERO:  v = '0;
            SRC_ANGLE: v = r_angle;
            SRC_BIAS:  v = r_bias;
            SRC_P00:   v = r_p00;
            SRC_P01:   v = r_p01;
            SRC_P10:   v = r_p10;
            SRC_P11:   v = r_p11;
            SRC_T:     v = r_t;
            SRC_D:     v = r_d;
            SRC_S:     v = r_s;
            SRC_K0:    v = r_k0;
            SRC_K1:    v = r_k1;
            SRC_Y:     v = r_y;
            SRC_P00T:  v = r_p00t;
            SRC_P01T:  v = r_p01t;
            SRC_MRES:  v = r_mres;
            SRC_DT:    v = $signed({8'd0, r_dt});
            SRC_QA:    v = $signed({1'b0, r_qa});
            SRC_QB:    v = $signed({1'b0, r_qb});
            SRC_R:     v = $signed({1'b0, r_r});
            SRC_MA:    v = r_ma;
            SRC_MR:    v = r_mr;
            default:   v = '0;
        endcase
        return v;
    endfunction

    assign w_in_acc   = i_valid && !o_stall;
    assign w_out_free = !r_ov || !i_stall;
    assign o_stall    = (r_state != ST_IDLE);
    assign o_valid    = r_ov;
    assign o_filtered_angle = r_out;

    always_comb begin
        w_mul_a   = sel_val(w_ctrl.mul_a);
        w_mul_b   = sel_val(w_ctrl.mul_b);
        w_add_a   = sel_val(w_ctrl.add_a);
        w_add_b   = sel_val(w_ctrl.add_b);
        w_div_num = sel_val(w_ctrl.div_num);
    end

    // Rounding stage: add half an LSB, floor and clamp.
    assign w_rnd   = r_prod + HALF;
    assign w_shift = w_rnd >>> FRAC_BITS;
    always_comb begin
        if (w_shift[63:31] == '0 || w_shift[63:31] == '1) begin
            w_mres = w_shift[31:0];
        end else if (w_shift[63]) begin
            w_mres = SAT_MIN;
        end else begin
            w_mres = SAT_MAX;
        end
    end

    assign w_sum = w_ctrl.add_sub ? (34'(w_add_a) - 34'(w_add_b))
                                  : (34'(w_add_a) + 34'(w_add_b));
    assign w_add = sat34(w_sum);

    akf_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_ctrl.div_start),
        .i_num   (w_div_num),
        .i_den   (r_s),
        .o_done  (w_div_done),
        .o_quot  (w_div_q)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (w_in_acc) n_state = ST_RATE;
            ST_RATE:  n_state = ST_M1;
            ST_M1:    n_state = ST_M2;
            ST_M2:    n_state = ST_A1;
            ST_A1:    n_state = ST_A2;
            ST_A2:    n_state = ST_T1;
            ST_T1:    n_state = ST_T2;
            ST_T2:    n_state = ST_T3;
            ST_T3:    n_state = ST_M3;
            ST_M3:    n_state = ST_W3;
            ST_W3:    n_state = ST_A3;
            ST_A3:    n_state = ST_A4;
            ST_A4:    n_state = ST_A5;
            ST_A5:    n_state = ST_S;
            ST_S:     n_state = ST_DIV0;
            ST_DIV0:  n_state = ST_DIV0W;
            ST_DIV0W: if (w_div_done) n_state = ST_DIV1;
            ST_DIV1:  n_state = ST_DIV1W;
            ST_DIV1W: if (w_div_done) n_state = ST_M4;
            ST_M4:    n_state = ST_M5;
            ST_M5:    n_state = ST_M6;
            ST_M6:    n_state = ST_M7;
            ST_M7:    n_state = ST_M8;
            ST_M8:    n_state = ST_M9;
            ST_M9:    n_state = ST_A10;
            ST_A10:   n_state = ST_A11;
            ST_A11:   n_state = ST_DONE;
            ST_DONE:  if (w_out_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // Micro-operations. A product issued in one state is registered in r_prod and then,
    // rounded, in r_mres, where it is read as SRC_MRES until the next product follows it.
    always_comb begin
        w_ctrl = '{mul_en: 1'b0, mul_a: SRC_ZERO, mul_b: SRC_ZERO,
                   add_a: SRC_ZERO, add_b: SRC_ZERO, add_sub: 1'b0,
                   add_dst: DST_NONE, div_start: 1'b0, div_num: SRC_P00};
        unique case (r_state)
            ST_RATE: begin
                w_ctrl.add_a = SRC_MR; w_ctrl.add_b = SRC_BIAS;
                w_ctrl.add_sub = 1'b1; w_ctrl.add_dst = DST_T;
            end
            ST_M1: begin
                w_ctrl.mul_en = 1'b1; w_ctrl.mul_a = SRC_DT; w_ctrl.mul_b = SRC_T;
            end
            ST_M2: begin
                w_ctrl.mul_en = 1'b1; w_ctrl.mul_a = SRC_DT; w_ctrl.mul_b = SRC_P11;
            end
            ST_A1: begin
                w_ctrl.add_a = SRC_ANGLE; w_ctrl.add_b = SRC_MRES;
                w_ctrl.add_dst = DST_ANGLE;
            end
            ST_A2: begin
                w_ctrl.add_a = SRC_MRES; w_ctrl.add_b = SRC_ZERO;
                w_ctrl.add_dst = DST_D;
            end
            ST_T1: begin
                w_ctrl.add_a = SRC_D; w_ctrl.add_b = SRC_P01;
                w_ctrl.add_sub = 1'b1; w_ctrl.add_dst = DST_T;
            end
            ST_T2: begin
                w_ctrl.add_a = SRC_T; w_ctrl.add_b = SRC_P10;
                w_ctrl.add_sub = 1'b1; w_ctrl.add_dst = DST_T;
            end
            ST_T3: begin
                w_ctrl.add_a = SRC_T; w_ctrl.add_b = SRC_QA;
                w_ctrl.add_dst = DST_T;
            end
            ST_M3: begin
                w_ctrl.mul_en = 1'b1; w_ctrl.mul_a = SRC_DT; w_ctrl.mul_b = SRC_T;
            end
            ST_W3: begin
                w_ctrl.add_a = SRC_P01; w_ctrl.add_b = SRC_D;
                w_ctrl.add_sub = 1'b1; w_ctrl.add_dst = DST_P01;
            end
            ST_A3: begin
                w_ctrl.add_a = SRC_P00; w_ctrl.add_b = SRC_MRES;
                w_ctrl.add_dst = DST_P00;
                w_ctrl.mul_en = 1'b1; w_ctrl.mul_a = SRC_QB; w_ctrl.mul_b = SRC_DT;
            end
            ST_A4: begin
                w_ctrl.add_a = SRC_P10; w_ctrl.add_b = SRC_D;
                w_ctrl.add_sub = 1'b1; w_ctrl.add_dst = DST_P10;
            end
            ST_A5: begin
                w_ctrl.add_a = SRC_P11; w_ctrl.add_b = SRC_MRES;
                w_ctrl.add_dst = DST_P11;
            end
            ST_S: begin
                w_ctrl.add_a = SRC_P00; w_ctrl.add_b = SRC_R;
                w_ctrl.add_dst = DST_S;
            end
            ST_DIV0: begin
                w_ctrl.div_start = 1'b1; w_ctrl.div_num = SRC_P00;
                w_ctrl.add_a = SRC_MA; w_ctrl.add_b = SRC_ANGLE;
                w_ctrl.add_sub = 1'b1; w_ctrl.add_dst = DST_Y;
            end
            ST_DIV1: begin
                w_ctrl.div_start = 1'b1; w_ctrl.div_num = SRC_P10;
            end
            ST_M4: begin
                w_ctrl.mul_en = 1'b1; w_ctrl.mul_a = SRC_K0; w_ctrl.mul_b = SRC_Y;
                w_ctrl.add_a = SRC_P00; w_ctrl.add_dst = DST_P00T;
            end
            ST_M5: begin
                w_ctrl.mul_en = 1'b1; w_ctrl.mul_a = SRC_K1; w_ctrl.mul_b = SRC_Y;
                w_ctrl.add_a = SRC_P01; w_ctrl.add_dst = DST_P01T;
            end
            ST_M6: begin
                w_ctrl.mul_en = 1'b1; w_ctrl.mul_a = SRC_K0; w_ctrl.mul_b = SRC_P00T;
                w_ctrl.add_a = SRC_ANGLE; w_ctrl.add_b = SRC_MRES;
                w_ctrl.add_dst = DST_ANGLE;
            end
            ST_M7: begin
                w_ctrl.mul_en = 1'b1; w_ctrl.mul_a = SRC_K0; w_ctrl.mul_b = SRC_P01T;
                w_ctrl.add_a = SRC_BIAS; w_ctrl.add_b = SRC_MRES;
                w_ctrl.add_dst = DST_BIAS;
            end
            ST_M8: begin
                w_ctrl.mul_en = 1'b1; w_ctrl.mul_a = SRC_K1; w_ctrl.mul_b = SRC_P00T;
                w_ctrl.add_a = SRC_P00; w_ctrl.add_b = SRC_MRES;
                w_ctrl.add_sub = 1'b1; w_ctrl.add_dst = DST_P00;
            end
            ST_M9: begin
                w_ctrl.mul_en = 1'b1; w_ctrl.mul_a = SRC_K1; w_ctrl.mul_b = SRC_P01T;
                w_ctrl.add_a = SRC_P01; w_ctrl.add_b = SRC_MRES;
                w_ctrl.add_sub = 1'b1; w_ctrl.add_dst = DST_P01;
            end
            ST_A10: begin
                w_ctrl.add_a = SRC_P10; w_ctrl.add_b = SRC_MRES;
                w_ctrl.add_sub = 1'b1; w_ctrl.add_dst = DST_P10;
            end
            ST_A11: begin
                w_ctrl.add_a = SRC_P11; w_ctrl.add_b = SRC_MRES;
                w_ctrl.add_sub = 1'b1; w_ctrl.add_dst = DST_P11;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ov    <= 1'b0;
            r_qa    <= RST_QA;
            r_qb    <= RST_QB;
            r_r     <= RST_R;
        end else begin
            r_state <= n_state;
            if (r_state == ST_DONE && w_out_free) begin
                r_ov <= 1'b1;
            end else if (r_ov && !i_stall) begin
                r_ov <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_IDX_QA: r_qa <= i_cfg_data;
                    CFG_IDX_QB: r_qb <= i_cfg_data;
                    CFG_IDX_R:  r_r  <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    // Filter state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_angle <= '0;
            r_bias  <= '0;
            r_p00   <= '0;
            r_p01   <= '0;
            r_p10   <= '0;
            r_p11   <= '0;
        end else begin
            unique case (w_ctrl.add_dst)
                DST_ANGLE: r_angle <= w_add;
                DST_BIAS:  r_bias  <= w_add;
                DST_P00:   r_p00   <= w_add;
                DST_P01:   r_p01   <= w_add;
                DST_P10:   r_p10   <= w_add;
                DST_P11:   r_p11   <= w_add;
                default: begin
                end
            endcase
        end
    end

    // Working registers and captured beat.
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_ma <= i_measured_angle;
            r_mr <= i_measured_rate;
            r_dt <= i_time_step;
        end
        unique case (w_ctrl.add_dst)
            DST_T:    r_t    <= w_add;
            DST_D:    r_d    <= w_add;
            DST_S:    r_s    <= w_add;
            DST_Y:    r_y    <= w_add;
            DST_P00T: r_p00t <= w_add;
            DST_P01T: r_p01t <= w_add;
            default: begin
            end
        endcase
        if (r_state == ST_DIV0W && w_div_done) begin
            r_k0 <= w_div_q;
        end
        if (r_state == ST_DIV1W && w_div_done) begin
            r_k1 <= w_div_q;
        end
        if (w_ctrl.mul_en) begin
            r_prod <= w_mul_a * w_mul_b;
        end
        r_mres <= w_mres;
        if (r_state == ST_DONE && w_out_free) begin
            r_out <= r_angle;
        end
    end

endmodule

`default_nettype wire

>>> rtl/akf_div.sv
// Bit-serial signed fixed-point divider that forms num * 2^FRAC_BITS / den, saturated.
`default_nettype none

module akf_div
    import akf_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [31:0] i_num,
    input  logic signed [31:0] i_den,
    output logic               o_done,
    output logic signed [31:0] o_quot
);

    localparam int DW = 32 + FRAC_BITS;
    localparam int CW = $clog2(DW);
    localparam logic [DW-1:0]   POS_LIM = DW'(64'h7FFF_FFFF);
    localparam logic [DW-1:0]   NEG_LIM = DW'(64'h8000_0000);
    localparam logic [CW-1:0]   LAST    = CW'(DW - 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [31:0]   r_rem;
    logic [DW-1:0] r_quo;
    logic [31:0]   r_den_mag;
    logic          r_neg;
    logic          r_zero;

    logic [31:0]   w_num_mag;
    logic [31:0]   w_den_mag;
    logic [32:0]   w_trial;
    logic          w_ge;
    logic [31:0]   w_q32;

    assign w_num_mag = i_num[31] ? (~$unsigned(i_num) + 32'd1) : $unsigned(i_num);
    assign w_den_mag = i_den[31] ? (~$unsigned(i_den) + 32'd1) : $unsigned(i_den);
    assign w_trial   = {r_rem, r_quo[DW-1]};
    assign w_ge      = (w_trial >= {1'b0, r_den_mag});
    assign w_q32     = r_quo[31:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CW'(1);
                if (r_cnt == LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Restoring division on magnitudes, one quotient bit per cycle.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem     <= '0;
            r_quo     <= {w_num_mag, {FRAC_BITS{1'b0}}};
            r_den_mag <= w_den_mag;
            r_neg     <= i_num[31] ^ i_den[31];
            r_zero    <= (i_den == '0);
        end else if (r_busy) begin
            r_rem <= w_ge ? 32'(w_trial - {1'b0, r_den_mag}) : w_trial[31:0];
            r_quo <= {r_quo[DW-2:0], w_ge};
        end
    end

    always_comb begin
        if (r_zero) begin
            o_quot = '0;
        end else if (!r_neg) begin
            o_quot = (r_quo > POS_LIM) ? SAT_MAX : $signed(w_q32);
        end else begin
            o_quot = (r_quo > NEG_LIM) ? SAT_MIN : $signed(~w_q32 + 32'd1);
        end
    end

    assign o_done = r_done;

endmodule

`default_nettype wire

>>> rtl/akf_chk.sv
// Port-level checker for the Kalman filter top level, bound to every instance.
`default_nettype none

module akf_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [31:0] o_filtered_angle
);

    // A waiting result beat keeps its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_filtered_angle))
        else $error("output beat changed while stalled");

    // An accepted beat keeps the input side busy for the computation.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall ##1 o_stall)
        else $error("input side ready too soon after a beat");

    // A result only appears at the end of a computation.
    a_result_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(o_stall))
        else $error("result beat without a computation");

    // Reset leaves no result pending and the input side ready.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("reset did not clear the handshake state");

endmodule

bind angle_bias_kalman_filter akf_chk u_akf_chk (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_valid          (i_valid),
    .o_stall          (o_stall),
    .o_valid          (o_valid),
    .i_stall          (i_stall),
    .o_filtered_angle (o_filtered_angle)
);

`default_nettype wire

>>> sim/tb.sv
// Self-checking testbench for the two-state angle and bias Kalman filter.
`default_nettype none

module tb
    import akf_pkg::*;
();

    localparam int         FRAC           = 16;
    localparam int         WATCHDOG_LIMIT = 10000;
    localparam int         DRAIN_CYCLES   = 130;
    localparam int         IDLE_SETTLE    = 4;
    localparam int         HOLD_CYCLES    = 1500;
    localparam logic [1:0] CFG_IDX_SPARE  = 2'd3;

    localparam logic [30:0] QA_DEFAULT = 31'd6554;
    localparam logic [30:0] QB_DEFAULT = 31'd19661;
    localparam logic [30:0] R_DEFAULT  = 31'd9830;

    // Tracks the filter state, predicts each filtered angle and checks the output beats.
    class kalman_tracker;
        logic        [30:0] q_angle, q_bias, r_meas;
        logic signed [31:0] angle, bias, p00, p01, p10, p11;
        logic signed [31:0] expected_angles[$];
        int                 errors;
        int                 checked;

        function new();
            q_angle = QA_DEFAULT;
            q_bias  = QB_DEFAULT;
            r_meas  = R_DEFAULT;
            angle   = '0;
            bias    = '0;
            p00     = '0;
            p01     = '0;
            p10     = '0;
            p11     = '0;
            errors  = 0;
            checked = 0;
        endfunction

        function logic signed [31:0] sat32(input longint v);
            if (v > 64'sd2147483647) return SAT_MAX;
            if (v < -64'sd2147483648) return SAT_MIN;
            return v[31:0];
        endfunction

        // Exact product, rounded half up at the binary point, then clamped.
        function logic signed [31:0] fixed_mul(input longint a, input longint b);
            longint p;
            p = a * b + (longint'(1) <<< (FRAC - 1));
            return sat32(p >>> FRAC);
        endfunction

        function logic signed [31:0] fixed_gain(input longint num, input longint den);
            if (den == 0) return '0;
            return sat32((num <<< FRAC) / den);
        endfunction

        function void write_reg(input logic [1:0] idx, input logic [30:0] val);
            case (idx)
                CFG_IDX_QA: q_angle = val;
                CFG_IDX_QB: q_bias  = val;
                CFG_IDX_R:  r_meas  = val;
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_angles.size();
        endfunction

        function void note_input(input logic signed [31:0] m_angle,
                                 input logic signed [31:0] m_rate,
                                 input logic        [23:0] dt);
            logic signed [31:0] rate, t, d, s, k0, k1, y, p00t, p01t;
            longint             step;
            step = longint'(dt);

            rate  = sat32(longint'(m_rate) - longint'(bias));
            angle = sat32(longint'(angle) + longint'(fixed_mul(step, rate)));

            t   = sat32(longint'(fixed_mul(step, p11)) - longint'(p01));
            t   = sat32(longint'(t) - longint'(p10));
            t   = sat32(longint'(t) + longint'(q_angle));
            p00 = sat32(longint'(p00) + longint'(fixed_mul(step, t)));
            d   = fixed_mul(step, p11);
            p01 = sat32(longint'(p01) - longint'(d));
            p10 = sat32(longint'(p10) - longint'(d));
            p11 = sat32(longint'(p11) + longint'(fixed_mul(longint'(q_bias), step)));

            s  = sat32(longint'(p00) + longint'(r_meas));
            k0 = fixed_gain(longint'(p00), longint'(s));
            k1 = fixed_gain(longint'(p10), longint'(s));

            y     = sat32(longint'(m_angle) - longint'(angle));
            angle = sat32(longint'(angle) + longint'(fixed_mul(k0, y)));
            bias  = sat32(longint'(bias) + longint'(fixed_mul(k1, y)));

            p00t = p00;
            p01t = p01;
            p00  = sat32(longint'(p00) - longint'(fixed_mul(k0, p00t)));
            p01  = sat32(longint'(p01) - longint'(fixed_mul(k0, p01t)));
            p10  = sat32(longint'(p10) - longint'(fixed_mul(k1, p00t)));
            p11  = sat32(longint'(p11) - longint'(fixed_mul(k1, p01t)));

            expected_angles.push_back(angle);
        endfunction

        function void report(input string msg);
            errors++;
            if (errors <= 10) $display("%s", msg);
        endfunction

        function void check_result(input logic signed [31:0] got);
            logic signed [31:0] want;
            if (expected_angles.size() == 0) begin
                report($sformatf("Output beat with no update pending: got %0d (0x%08h)",
                                 got, got));
            end else begin
                want = expected_angles.pop_front();
                if (got !== want) begin
                    report($sformatf({"Filtered angle mismatch on beat %0d: ",
                                      "expected %0d (0x%08h), got %0d (0x%08h)"},
                                     checked, want, want, got, got));
                end
                checked++;
            end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic signed [31:0] i_measured_angle;
    logic signed [31:0] i_measured_rate;
    logic        [23:0] i_time_step;
    logic               o_valid;
    logic               i_stall;
    logic signed [31:0] o_filtered_angle;
    logic               i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic        [30:0] i_cfg_data;

    kalman_tracker tracker;
    int            send_idle_pct   = 0;
    int            recv_stall_pct  = 0;
    int            hold_off_cycles = 0;
    int            quiet_cycles    = 0;
    int            n_settings      = 0;

    angle_bias_kalman_filter #(.FRAC_BITS(FRAC)) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_measured_angle (i_measured_angle),
        .i_measured_rate  (i_measured_rate),
        .i_time_step      (i_time_step),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_filtered_angle (o_filtered_angle),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Beat monitor and watchdog, both sampling pre-edge values.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                tracker.note_input(i_measured_angle, i_measured_rate, i_time_step);
            end
            if (o_valid && !i_stall) begin
                tracker.check_result(o_filtered_angle);
            end
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Timeout: no beat moved for %0d cycles", WATCHDOG_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // Output side: random stalls, plus one long hold-off when asked for.
    initial begin : receiver
        int n;
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_cycles > 0) begin
                n = hold_off_cycles;
                hold_off_cycles = 0;
                i_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
            i_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    task automatic send_item(input logic signed [31:0] m_angle,
                             input logic signed [31:0] m_rate,
                             input logic        [23:0] dt);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid          <= 1'b1;
        i_measured_angle <= m_angle;
        i_measured_rate  <= m_rate;
        i_time_step      <= dt;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    // Plausible sensor readings, but for about wild_pct percent that span every bit of the fields.
    task automatic send_random(input int wild_pct);
        logic signed [31:0] m_angle, m_rate;
        logic        [23:0] dt;
        if ($urandom_range(99) < wild_pct) begin
            m_angle = $urandom();
            m_rate  = $urandom();
            dt      = 24'($urandom());
        end else begin
            m_angle = $urandom_range(11_796_480) - 5_898_240;
            m_rate  = $urandom_range(32_768_000) - 16_384_000;
            dt      = 24'($urandom_range(3300, 30));
        end
        send_item(m_angle, m_rate, dt);
    endtask

    // The monitor notes the last accepted beat at the same edge at which the
    // sender returns, so wait_idle waits for the next edge before it trusts the pending count.
    task automatic wait_idle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (IDLE_SETTLE) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [30:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        tracker.write_reg(idx, val);
    endtask

    // Writes all three noise registers and pokes the unused index, which must be ignored.
    task automatic program_filter(input logic [30:0] qa, qb, r);
        cfg_write(CFG_IDX_QA, qa);
        cfg_write(CFG_IDX_QB, qb);
        cfg_write(CFG_IDX_R, r);
        cfg_write(CFG_IDX_SPARE, 31'($urandom()));
        i_cfg_we <= 1'b0;
        n_settings++;
    endtask

    task automatic run_phase(input logic [30:0] qa, qb, r, input int send_pct, recv_pct,
                             input int n_items, wild_pct, hold);
        wait_idle();
        program_filter(qa, qb, r);
        send_idle_pct   = send_pct;
        recv_stall_pct  = recv_pct;
        hold_off_cycles = hold;
        repeat (n_items) send_random(wild_pct);
    endtask

    initial begin
        tracker = new();
        i_rst_n          <= 1'b0;
        i_valid          <= 1'b0;
        i_measured_angle <= '0;
        i_measured_rate  <= '0;
        i_time_step      <= '0;
        i_cfg_we         <= 1'b0;
        i_cfg_index      <= CFG_IDX_QA;
        i_cfg_data       <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // With every noise term at zero the covariance stays zero, so S is zero
        // and both gains must come out as zero.
        program_filter(31'd0, 31'd0, 31'd0);
        send_item(32'sh0001_0000, 32'sh0000_0000, 24'd655);
        send_item(SAT_MAX, SAT_MIN, 24'hFF_FFFF);
        send_item(SAT_MIN, SAT_MAX, 24'd1);

        wait_idle();
        program_filter(QA_DEFAULT, QB_DEFAULT, R_DEFAULT);
        send_item(32'sh0000_0000, 32'sh0000_0000, 24'd0);
        send_item(SAT_MAX, 32'sh0000_0000, 24'd655);
        send_item(SAT_MIN, 32'sh0000_0000, 24'd655);
        send_item(32'sh0000_0000, SAT_MAX, 24'd655);
        send_item(32'sh0000_0000, SAT_MIN, 24'd655);
        send_item(SAT_MAX, SAT_MAX, 24'hFF_FFFF);
        send_item(SAT_MIN, SAT_MIN, 24'hFF_FFFF);
        send_item(32'sh5555_5555, 32'shAAAA_AAAA, 24'h55_5555);
        send_item(32'shAAAA_AAAA, 32'sh5555_5555, 24'hAA_AAAA);
        send_item(32'sh0001_0000, 32'sh0001_0000, 24'd1);
        send_item(-32'sh0001_0000, -32'sh0001_0000, 24'd0);
        send_item(32'sh0000_0000, 32'sh0000_0000, 24'd655);
        send_item(32'sh0000_0000, 32'sh0000_0000, 24'd655);

        run_phase(31'd655, 31'd1311, 31'd32768, 0, 0, 60, 0, 0);
        run_phase(31'($urandom_range(200000, 1)), 31'($urandom_range(200000, 1)),
                  31'($urandom_range(200000, 1)), 65, 0, 60, 5, 0);
        // Output held off for a long stretch while inputs keep coming, so the
        // block fills up and has to stall its input.
        run_phase(31'($urandom_range(200000, 1)), 31'($urandom_range(200000, 1)),
                  31'($urandom_range(200000, 1)), 0, 65, 60, 0, HOLD_CYCLES);
        run_phase(31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 6, 6, 60, 10, 0);
        run_phase(31'h7FFF_FFFF, 31'd0, 31'd0, 0, 0, 50, 30, 0);
        run_phase(31'($urandom()), 31'($urandom()), 31'($urandom()), 65, 0, 50, 50, 0);
        run_phase(31'($urandom_range(200000, 1)), 31'($urandom_range(200000, 1)),
                  31'($urandom_range(200000, 1)), 0, 65, 60, 20, 0);

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Checked %0d filtered angles over %0d noise settings, with zero gains,",
                 tracker.checked, n_settings);
        $display("saturating inputs, idle gaps, output stalls and a long hold-off; %0d errors.",
                 tracker.errors);
        if (tracker.errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

`default_nettype wire
